// File: hw/rtl/smfc_pkg.sv
package smfc_pkg;

    localparam int unsigned FifoDepth = 64;
    localparam int unsigned PtrW = $clog2(FifoDepth);
    localparam int unsigned CntW = PtrW + 1;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_BYTE  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [13:0] OFF_RXD = 14'h00;
    localparam logic [13:0] OFF_TXD = 14'h04;
    localparam logic [13:0] OFF_CON = 14'h08;
    localparam logic [13:0] OFF_SET = 14'h0C;
    localparam logic [13:0] OFF_IEN = 14'h10;
    localparam logic [13:0] OFF_DMA = 14'h14;
    localparam logic [13:0] OFF_STA = 14'h18;
    localparam logic [13:0] OFF_PER = 14'h1C;
    localparam logic [13:0] OFF_TST = 14'h20;
    localparam logic [13:0] OFF_MSG = 14'h24;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] reg_offset;
        logic [31:0] write_data;
        logic [7:0]  spi_rx_byte;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic [7:0]  spi_tx_byte;
        logic        spi_tx_valid;
        logic        busy_res;
        logic        irq_level;
    } t_res;

endpackage

// File: hw/rtl/smfc_if.sv
interface smfc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/smfc_fifo.sv
// word fifo with count; read data registered, valid the cycle after the pop
module smfc_fifo import smfc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_flush,
    input  logic            i_push,
    input  logic [31:0]     i_push_data,
    input  logic            i_pop,
    output logic [31:0]     o_head_data,
    output logic [CntW-1:0] o_count
);
    logic [31:0]     r_mem [FifoDepth];
    logic [PtrW-1:0] r_head;
    logic [PtrW-1:0] r_tail;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_head;

    always_comb begin
        n_head = r_head;
        if (i_pop && r_count != '0) begin
            n_head = (r_head == PtrW'(FifoDepth - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_flush) begin
            n_head = '0;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head <= n_head;
            if (i_push) begin
                r_tail <= (r_tail == PtrW'(FifoDepth - 1)) ? '0 : r_tail + 1'b1;
            end
            r_count <= r_count + CntW'(i_push) - CntW'(i_pop && r_count != '0);
        end
    end

    // storage; read always shows the next head word
    always_ff @(posedge i_clk) begin
        if (i_push && !i_flush) begin
            r_mem[r_tail] <= i_push_data;
        end
        o_head_data <= (i_push && !i_flush && r_tail == n_head) ? i_push_data : r_mem[n_head];
    end

    assign o_count = r_count;
endmodule

// File: hw/rtl/spi_master_fifo_controller.sv
// SPI master register block with 64-word TX and RX FIFOs. Each request (bus read, bus write or
// partner byte) is decoded when accepted and its result lands in an output register in the cycle
// after, so a new request may enter every cycle while that register is empty or its result is
// being taken. FIFO heads are prefetched into registers, so a popped word needs no memory read.
// Unknown offsets and bus accesses during an exchange report access_error and change nothing.
module spi_master_fifo_controller import smfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    smfc_if.sink   i_req,
    smfc_if.source o_res
);
    logic r_ovf, r_tc, r_irq, r_act;
    logic [1:0]  r_bidx;
    logic [2:0]  r_bpw;
    logic [31:0] r_txw, r_asm;
    logic [31:0] r_con, r_set, r_ien, r_dma, r_per, r_tst;
    logic        r_valid;
    t_res        r_res;

    logic [31:0] tx_head, rx_head;
    logic [CntW-1:0] tx_cnt, rx_cnt;

    logic accept;
    t_req q;
    logic tx_push, tx_pop, rx_push, rx_pop, flush;
    logic [31:0] rx_word;

    logic n_ovf, n_tc, n_irq, n_act;
    logic [1:0] n_bidx;
    logic [2:0] n_bpw;
    logic [31:0] n_txw, n_asm, n_con, n_set, n_ien, n_dma, n_per, n_tst;
    logic [31:0] rdata;
    logic err, upd;
    logic [CntW-1:0] tx_c2, rx_c2;
    logic [7:0] st2;
    logic [12:0] bits;
    logic [10:0] nb;

    assign accept = i_req.valid && i_req.ready;
    assign q = i_req.data;
    assign i_req.ready = !r_valid || o_res.ready;

    function automatic logic [7:0] status(logic ov, logic tc, logic [CntW-1:0] tc_n,
                                          logic [CntW-1:0] rc_n);
        logic [7:0] s;
        s = 8'h0;
        s[6] = ov;
        s[7] = tc;
        if (tc_n == '0) s[1:0] = 2'b11;
        if (tc_n >= CntW'(FifoDepth)) s[2] = 1'b1;
        if (rc_n != '0) s[4:3] = 2'b11;
        if (rc_n >= CntW'(FifoDepth)) s[5] = 1'b1;
        return s;
    endfunction

    // request decode and next state
    always_comb begin
        n_ovf = r_ovf; n_tc = r_tc; n_irq = r_irq; n_act = r_act;
        n_bidx = r_bidx; n_bpw = r_bpw; n_txw = r_txw; n_asm = r_asm;
        n_con = r_con; n_set = r_set; n_ien = r_ien; n_dma = r_dma;
        n_per = r_per; n_tst = r_tst;
        rdata = '0; err = 1'b0; upd = 1'b0;
        tx_push = 1'b0; tx_pop = 1'b0; rx_push = 1'b0; rx_pop = 1'b0; flush = 1'b0;
        rx_word = '0;
        tx_c2 = tx_cnt; rx_c2 = rx_cnt;
        bits = {1'b0, q.write_data[31:20]} + 13'd1;
        nb = 11'((bits + 13'd7) >> 3);
        if (accept) begin
            unique case (t_action'(q.action))
                ACT_READ: begin
                    if (r_act) begin
                        err = 1'b1;
                    end else begin
                        unique case (q.reg_offset)
                            OFF_RXD: begin
                                if (rx_cnt != '0) begin
                                    rdata = rx_head;
                                    rx_pop = 1'b1;
                                    rx_c2 = rx_cnt - 1'b1;
                                end
                                upd = 1'b1;
                            end
                            OFF_CON: rdata = r_con;
                            OFF_SET: rdata = r_set;
                            OFF_IEN: rdata = r_ien;
                            OFF_DMA: rdata = r_dma;
                            OFF_STA: rdata = {24'h0, status(r_ovf, r_tc, tx_cnt, rx_cnt)};
                            OFF_PER: rdata = r_per;
                            OFF_TST: rdata = r_tst;
                            default: err = 1'b1;
                        endcase
                    end
                end
                ACT_WRITE: begin
                    if (r_act) begin
                        err = 1'b1;
                    end else begin
                        unique case (q.reg_offset)
                            OFF_TXD: begin
                                if (tx_cnt < CntW'(FifoDepth)) tx_push = 1'b1;
                            end
                            OFF_CON: begin
                                n_con = q.write_data;
                                if (!q.write_data[0]) begin
                                    flush = 1'b1;
                                    tx_c2 = '0; rx_c2 = '0;
                                    upd = 1'b1;
                                end else if (q.write_data[2]) begin
                                    n_bpw = (nb > 11'd4) ? 3'd4 : nb[2:0];
                                    n_con[2] = 1'b0;
                                    upd = 1'b1;
                                    n_bidx = '0;
                                    if (tx_cnt == '0) begin
                                        n_act = 1'b0; n_tc = 1'b1;
                                    end else begin
                                        n_txw = tx_head; tx_pop = 1'b1;
                                        tx_c2 = tx_cnt - 1'b1;
                                        n_asm = '0; n_act = 1'b1;
                                    end
                                end else begin
                                    upd = 1'b1;
                                end
                            end
                            OFF_SET: n_set = q.write_data;
                            OFF_IEN: begin n_ien = q.write_data; upd = 1'b1; end
                            OFF_DMA: n_dma = q.write_data;
                            OFF_STA: begin
                                if (q.write_data[6]) n_ovf = 1'b0;
                                if (q.write_data[7]) n_tc = 1'b0;
                                upd = 1'b1;
                            end
                            OFF_PER: n_per = q.write_data;
                            OFF_TST: n_tst = q.write_data;
                            OFF_MSG: ;
                            default: err = 1'b1;
                        endcase
                    end
                end
                ACT_BYTE: begin
                    if (r_act) begin
                        rx_word = r_asm | (32'(q.spi_rx_byte) << {r_bidx, 3'b000});
                        n_asm = rx_word;
                        if ({1'b0, r_bidx} + 3'd1 >= r_bpw) begin
                            if (rx_cnt < CntW'(FifoDepth)) begin
                                rx_push = 1'b1; rx_c2 = rx_cnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_bidx = '0;
                            if (tx_cnt == '0) begin
                                n_act = 1'b0; n_tc = 1'b1; upd = 1'b1;
                            end else begin
                                n_txw = tx_head; tx_pop = 1'b1;
                                tx_c2 = tx_cnt - 1'b1; n_asm = '0;
                            end
                        end else begin
                            n_bidx = r_bidx + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        st2 = status(n_ovf, n_tc, tx_c2, rx_c2);
        if (upd) n_irq = (st2 & n_ien[7:0]) != 8'h0;
    end

    smfc_fifo u_tx (
        .i_clk, .i_rst_n, .i_flush(flush), .i_push(tx_push), .i_push_data(q.write_data),
        .i_pop(tx_pop), .o_head_data(tx_head), .o_count(tx_cnt)
    );
    smfc_fifo u_rx (
        .i_clk, .i_rst_n, .i_flush(flush), .i_push(rx_push), .i_push_data(rx_word),
        .i_pop(rx_pop), .o_head_data(rx_head), .o_count(rx_cnt)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0; r_tc <= 1'b0; r_irq <= 1'b0; r_act <= 1'b0;
            r_bidx <= '0; r_bpw <= 3'd1; r_txw <= '0; r_asm <= '0;
            r_con <= '0; r_set <= '0; r_ien <= '0; r_dma <= '0; r_per <= '0; r_tst <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ovf <= n_ovf; r_tc <= n_tc; r_irq <= n_irq; r_act <= n_act;
            r_bidx <= n_bidx; r_bpw <= n_bpw; r_txw <= n_txw; r_asm <= n_asm;
            r_con <= n_con; r_set <= n_set; r_ien <= n_ien; r_dma <= n_dma;
            r_per <= n_per; r_tst <= n_tst;
            if (accept) r_valid <= 1'b1;
            else if (o_res.ready) r_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res.read_data    <= rdata;
            r_res.access_error <= err;
            r_res.spi_tx_byte  <= n_act ? 8'(n_txw >> {n_bidx, 3'b000}) : 8'h0;
            r_res.spi_tx_valid <= n_act;
            r_res.busy_res     <= n_act;
            r_res.irq_level    <= n_irq;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_res;

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.access_error |-> r_res.read_data == '0) else $error("err with data");
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_res.busy_res == r_res.spi_tx_valid) else $error("busy mismatch");
    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_cnt <= CntW'(FifoDepth) && rx_cnt <= CntW'(FifoDepth)) else $error("fifo count");
endmodule

// File: test/smfc_checker.sv
module smfc_checker import smfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    smfc_if      req_mon,
    smfc_if      res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    // shadow copy of the controller state
    logic [31:0] ctl_word, setup_word, ien_word, dma_word, period_word, test_word;
    bit          ovf_flag, done_flag, irq_line, xfer_on;
    int          byte_idx, word_bytes;
    logic [31:0] cur_tx_word, rx_acc;
    logic [31:0] tx_words[$];
    logic [31:0] rx_words[$];
    t_res        pending_results[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_results.size();

    function automatic logic [31:0] status_word();
        logic [31:0] s;
        s = '0;
        if (ovf_flag) s[6] = 1'b1;
        if (done_flag) s[7] = 1'b1;
        if (tx_words.size() == 0) s[1:0] = 2'b11;
        if (tx_words.size() >= FifoDepth) s[2] = 1'b1;
        if (rx_words.size() != 0) s[4:3] = 2'b11;
        if (rx_words.size() >= FifoDepth) s[5] = 1'b1;
        return s;
    endfunction

    task automatic refresh_irq();
        irq_line = (status_word() & ien_word & 32'hFF) != 0;
    endtask

    // load the next tx word or close the burst
    task automatic next_tx_word();
        if (tx_words.size() == 0) begin
            xfer_on   = 0;
            byte_idx  = 0;
            done_flag = 1;
            refresh_irq();
        end else begin
            cur_tx_word = tx_words[0];
            tx_words.delete(0);
            rx_acc      = '0;
            byte_idx    = 0;
            xfer_on     = 1;
        end
    endtask

    task automatic take_partner_byte(input logic [7:0] b);
        int idx;
        idx = byte_idx;
        rx_acc = rx_acc | (32'(b) << (8 * idx));
        if (idx + 1 >= word_bytes) begin
            if (rx_words.size() < FifoDepth) rx_words = {rx_words, rx_acc};
            else ovf_flag = 1;
            next_tx_word();
        end else begin
            byte_idx = idx + 1;
        end
    endtask

    task automatic bus_read(input logic [13:0] off, output logic [31:0] val, output bit ok);
        val = '0;
        ok  = 1;
        case (off)
            OFF_RXD: begin
                if (rx_words.size() != 0) begin
                    val = rx_words[0];
                    rx_words.delete(0);
                end
                refresh_irq();
            end
            OFF_CON: val = ctl_word;
            OFF_SET: val = setup_word;
            OFF_IEN: val = ien_word;
            OFF_DMA: val = dma_word;
            OFF_STA: val = status_word();
            OFF_PER: val = period_word;
            OFF_TST: val = test_word;
            default: ok = 0;
        endcase
    endtask

    task automatic bus_write(input logic [13:0] off, input logic [31:0] v, output bit ok);
        int nbits, nb;
        ok = 1;
        case (off)
            OFF_TXD: if (tx_words.size() < FifoDepth) tx_words = {tx_words, v};
            OFF_CON: begin
                ctl_word = v;
                if (!v[0]) begin
                    tx_words.delete();
                    rx_words.delete();
                    refresh_irq();
                end else if (v[2]) begin
                    nbits = int'(v[31:20]) + 1;
                    nb = (nbits + 7) / 8;
                    word_bytes = (nb > 4) ? 4 : nb;
                    ctl_word[2] = 1'b0;
                    next_tx_word();
                    if (xfer_on) refresh_irq();
                end else begin
                    refresh_irq();
                end
            end
            OFF_SET: setup_word = v;
            OFF_IEN: begin
                ien_word = v;
                refresh_irq();
            end
            OFF_DMA: dma_word = v;
            OFF_STA: begin
                if (v[6]) ovf_flag = 0;
                if (v[7]) done_flag = 0;
                refresh_irq();
            end
            OFF_PER: period_word = v;
            OFF_TST: test_word = v;
            OFF_MSG: ;
            default: ok = 0;
        endcase
    endtask

    task automatic predict_result(input t_req r, output t_res o);
        logic [31:0] rd;
        bit          ok, err;
        rd  = '0;
        err = 0;
        case (t_action'(r.action))
            ACT_READ, ACT_WRITE: begin
                if (xfer_on) begin
                    err = 1;
                end else if (t_action'(r.action) == ACT_READ) begin
                    bus_read(r.reg_offset, rd, ok);
                    err = !ok;
                end else begin
                    bus_write(r.reg_offset, r.write_data, ok);
                    err = !ok;
                end
                if (err) rd = '0;
            end
            ACT_BYTE: if (xfer_on) take_partner_byte(r.spi_rx_byte);
            default: ;
        endcase
        o.read_data    = rd;
        o.access_error = err;
        o.spi_tx_byte  = xfer_on ? cur_tx_word[8 * byte_idx +: 8] : 8'h00;
        o.spi_tx_valid = xfer_on;
        o.busy_res     = xfer_on;
        o.irq_level    = irq_line;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    // compare results, then predict the request taken on this edge
    always @(posedge i_clk) begin
        t_res want, got, pred;
        if (!i_rst_n) begin
            ctl_word = '0; setup_word = '0; ien_word = '0;
            dma_word = '0; period_word = '0; test_word = '0;
            ovf_flag = 0; done_flag = 0; irq_line = 0; xfer_on = 0;
            byte_idx = 0; word_bytes = 1;
            cur_tx_word = '0; rx_acc = '0;
            tx_words.delete();
            rx_words.delete();
            pending_results.delete();
            fail_count = 0;
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                got = res_mon.data;
                if (pending_results.size() == 0) begin
                    report("unexpected result", got.read_data, 32'h0);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.read_data !== want.read_data)
                        report("read_data", got.read_data, want.read_data);
                    if (got.access_error !== want.access_error)
                        report("access_error", 32'(got.access_error), 32'(want.access_error));
                    if (got.spi_tx_byte !== want.spi_tx_byte)
                        report("spi_tx_byte", 32'(got.spi_tx_byte), 32'(want.spi_tx_byte));
                    if (got.spi_tx_valid !== want.spi_tx_valid)
                        report("spi_tx_valid", 32'(got.spi_tx_valid), 32'(want.spi_tx_valid));
                    if (got.busy_res !== want.busy_res)
                        report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                    if (got.irq_level !== want.irq_level)
                        report("irq_level", 32'(got.irq_level), 32'(want.irq_level));
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                predict_result(req_mon.data, pred);
                pending_results = {pending_results, pred};
            end
        end
    end

endmodule

// File: test/tb_spi_master_fifo_controller.sv
module tb_spi_master_fifo_controller;
    import smfc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent_items;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_off;
    bit   start_hold;

    smfc_if #(.T(t_req)) req_if ();
    smfc_if #(.T(t_res)) res_if ();

    spi_master_fifo_controller u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    smfc_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_if),
        .res_mon      (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // result side backpressure
    always @(posedge i_clk) begin
        res_if.ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall so the request side fills up
    initial begin
        hold_off = 0;
        wait (start_hold);
        @(posedge i_clk);
        hold_off <= 1;
        repeat (400) @(posedge i_clk);
        hold_off <= 0;
    end

    initial begin
        #(12 * 600000);
        $display("spi_master_fifo_controller regression: fail");
        $finish;
    end

    task automatic send(input t_action a, input logic [13:0] off, input logic [31:0] wd,
                        input logic [7:0] b);
        t_req r;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        r.action      = a;
        r.reg_offset  = off;
        r.write_data  = wd;
        r.spi_rx_byte = b;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sent_items++;
    endtask

    function automatic logic [13:0] pick_offset();
        case ($urandom_range(11))
            0: return OFF_RXD;
            1: return OFF_TXD;
            2: return OFF_CON;
            3: return OFF_SET;
            4: return OFF_IEN;
            5: return OFF_DMA;
            6: return OFF_STA;
            7: return OFF_PER;
            8: return OFF_TST;
            9: return OFF_MSG;
            default: return 14'($urandom());
        endcase
    endfunction

    function automatic logic [11:0] pick_burst_len();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'd7;
            2: return 12'd8;
            3: return 12'd15;
            4: return 12'd16;
            5: return 12'd23;
            6: return 12'd24;
            7: return 12'd4095;
            default: return 12'($urandom());
        endcase
    endfunction

    // enable, load words, start the exchange and answer every byte
    task automatic run_burst(input int words, input logic [11:0] blen);
        int nb, nbytes;
        logic [31:0] ctl;
        nb = (int'(blen) + 8) / 8;
        if (nb > 4) nb = 4;
        send(ACT_WRITE, OFF_CON, 32'h1 | (32'($urandom()) & 32'h000F_FFF8), 8'h00);
        for (int i = 0; i < words; i++)
            send(ACT_WRITE, OFF_TXD, $urandom(), 8'h00);
        ctl = {blen, 20'($urandom())} | 32'h5;
        send(ACT_WRITE, OFF_CON, ctl, 8'h00);
        nbytes = words * nb + $urandom_range(2);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(19) == 0)
                send(t_action'($urandom_range(1)), pick_offset(), $urandom(), 8'h00);
            send(ACT_BYTE, 14'($urandom()), $urandom(), 8'($urandom()));
        end
    endtask

    initial begin
        int r, words;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        res_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        sent_items    = 0;
        send_idle_pct = 15;
        recv_idle_pct = 84;
        start_hold    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, bad offsets, empty cases, extremes
        send(ACT_READ, OFF_STA, 32'h0, 8'h00);
        send(ACT_READ, OFF_RXD, 32'h0, 8'h00);
        send(ACT_READ, 14'h02, 32'h0, 8'h00);
        send(ACT_READ, OFF_TXD, 32'h0, 8'h00);
        send(ACT_READ, OFF_MSG, 32'h0, 8'h00);
        send(ACT_WRITE, OFF_RXD, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, 14'h3FFF, 32'hFFFF_FFFF, 8'hFF);
        send(ACT_BYTE, 14'h0, 32'h0, 8'hFF);
        send(ACT_NONE, 14'h3FFF, 32'hFFFF_FFFF, 8'hFF);
        send(ACT_WRITE, OFF_IEN, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_SET, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_DMA, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_PER, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_TST, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_MSG, 32'hFFFF_FFFF, 8'h00);
        send(ACT_WRITE, OFF_CON, 32'h5, 8'h00);
        send(ACT_READ, OFF_STA, 32'h0, 8'h00);
        send(ACT_WRITE, OFF_STA, 32'h0000_00C0, 8'h00);
        run_burst(2, 12'd4095);
        send(ACT_READ, OFF_RXD, 32'h0, 8'h00);
        send(ACT_WRITE, OFF_CON, 32'h0, 8'h00);
        send(ACT_READ, OFF_CON, 32'h0, 8'h00);

        // random: mostly well-formed bursts among register traffic
        while (sent_items < 1250) begin
            if (sent_items >= 840) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent_items >= 420) begin
                send_idle_pct = 84;
                recv_idle_pct = 15;
            end
            if (sent_items >= 900) start_hold = 1;
            r = $urandom_range(99);
            if (r < 35) begin
                words = ($urandom_range(14) == 0) ? $urandom_range(70, 60) : $urandom_range(6);
                run_burst(words, pick_burst_len());
            end else if (r < 55) begin
                send(ACT_READ, pick_offset(), $urandom(), 8'($urandom()));
            end else if (r < 75) begin
                send(ACT_WRITE, pick_offset(), $urandom(), 8'($urandom()));
            end else if (r < 88) begin
                send(ACT_BYTE, 14'($urandom()), $urandom(), 8'($urandom()));
            end else if (r < 93) begin
                send(ACT_WRITE, OFF_STA, $urandom(), 8'h00);
            end else if (r < 97) begin
                send(ACT_WRITE, OFF_IEN, $urandom(), 8'h00);
            end else begin
                send(ACT_NONE, 14'($urandom()), $urandom(), 8'($urandom()));
            end
        end
        req_if.valid <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("spi_master_fifo_controller regression: pass");
        end else begin
            $display("spi_master_fifo_controller regression: fail");
        end
        $finish;
    end

endmodule
